// ===== sv/qprm_pkg.sv =====
// Package for the queued PCM resample mixer: sizes, op codes, register
// indexes, controller states and the controller/datapath command struct.
// No dependencies.
package qprm_pkg;

  localparam int unsigned FifoDepth = 4096;
  localparam int unsigned IdxW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = IdxW + 1;
  localparam logic [23:0] PosOne    = 24'h010000;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_PULL  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  localparam logic [1:0] RegMode  = 2'd0;
  localparam logic [1:0] RegStep  = 2'd1;
  localparam logic [1:0] RegGainL = 2'd2;
  localparam logic [1:0] RegGainR = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAIN1,
    ST_RD_HEAD,
    ST_RD_NEXT,
    ST_MUL,
    ST_SUM,
    ST_DRAIN2,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic push;
    logic clear;
    logic drop;
    logic rd_head;
    logic rd_next;
    logic mul;
    logic sum;
    logic set_under;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       can_drop;
    logic       empty;
  } sts_t;

endpackage

// ===== sv/queued_pcm_resample_mixer_unit.sv =====
// Top level of the queued PCM resample mixer with its APB register bank.
// Depends on qprm_pkg, qprm_ctrl and qprm_datapath.
//
// Each item runs through the controller states in turn; a pull drains spent
// frames before and after its reads, paced by the single read port of the
// 4096-frame memory. The next item is taken while a result waits in the
// output register.
module queued_pcm_resample_mixer_unit
  import qprm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        op_i,
  input  logic [15:0]       sample_left_i,
  input  logic [15:0]       sample_right_i,
  input  logic              end_of_buffer_i,
  input  logic [31:0]       acc_left_i,
  input  logic [31:0]       acc_right_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              accepted_o,
  output logic [31:0]       mixed_left_o,
  output logic [31:0]       mixed_right_o,
  output logic              underrun_o,
  output logic [12:0]       buffers_completed_o,
  output logic [12:0]       fifo_level_o
);

  logic        mode_q;
  logic [23:0] step_q;
  logic [15:0] gl_q, gr_q;
  cmd_t        cmd;
  sts_t        sts;

  assign pready = 1'b1;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      step_q <= 24'd65536;
      gl_q   <= 16'd4096;
      gr_q   <= 16'd4096;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        RegMode:  mode_q <= pwdata[0];
        RegStep:  step_q <= pwdata[23:0];
        RegGainL: gl_q   <= pwdata[15:0];
        RegGainR: gr_q   <= pwdata[15:0];
        default:  ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (paddr[3:2])
      RegMode:  prdata = {31'd0, mode_q};
      RegStep:  prdata = {8'd0, step_q};
      RegGainL: prdata = {16'd0, gl_q};
      RegGainR: prdata = {16'd0, gr_q};
      default:  prdata = '0;
    endcase
  end

  qprm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  qprm_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .op_i, .sample_left_i,
    .sample_right_i, .end_of_buffer_i, .acc_left_i, .acc_right_i,
    .mode_i(mode_q), .step_i(step_q), .gain_l_i(gl_q), .gain_r_i(gr_q),
    .accepted_o, .mixed_left_o, .mixed_right_o, .underrun_o,
    .buffers_completed_o, .fifo_level_o
  );

endmodule

// ===== sv/qprm_datapath.sv =====
// Datapath of the queued PCM resample mixer: frame memory, queue pointers,
// read position, interpolation, gain multiply and output register.
// Depends on qprm_pkg.
module qprm_datapath
  import qprm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output sts_t              sts_o,
  input  logic [1:0]        op_i,
  input  logic [15:0]       sample_left_i,
  input  logic [15:0]       sample_right_i,
  input  logic              end_of_buffer_i,
  input  logic [31:0]       acc_left_i,
  input  logic [31:0]       acc_right_i,
  input  logic              mode_i,
  input  logic [23:0]       step_i,
  input  logic [15:0]       gain_l_i,
  input  logic [15:0]       gain_r_i,
  output logic              accepted_o,
  output logic [31:0]       mixed_left_o,
  output logic [31:0]       mixed_right_o,
  output logic              underrun_o,
  output logic [CntW-1:0]   buffers_completed_o,
  output logic [CntW-1:0]   fifo_level_o
);

  logic [32:0]     mem [FifoDepth];
  logic [32:0]     rd_q;
  logic [32:0]     f0_q, f1_q;
  logic [IdxW-1:0] head_q;
  logic [CntW-1:0] count_q;
  logic [23:0]     pos_q;
  logic [CntW-1:0] done_q;
  logic            under_q, acc_q;
  logic [1:0]      op_q;
  logic [15:0]     sl_q, sr_q;
  logic            eob_q;
  logic [31:0]     accl_q, accr_q;
  logic signed [33:0] vl_q, vr_q;
  logic signed [49:0] pl_q, pr_q;

  logic [IdxW-1:0] tail, rd_addr;
  logic            full;
  logic [24:0]     pos_sum;

  assign full    = count_q == CntW'(FifoDepth);
  assign tail    = head_q + count_q[IdxW-1:0];
  // While the head frame is taken, the frame after it is addressed so that
  // it lands in rd_q in the following cycle.
  assign rd_addr = cmd_i.rd_head ? head_q + IdxW'(1) : head_q;
  assign pos_sum = {1'b0, pos_q} + {1'b0, step_i};

  assign sts_o.op       = op_q;
  assign sts_o.can_drop = (count_q != '0) && (pos_q >= PosOne);
  assign sts_o.empty    = count_q == '0;

  // Frame memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full) begin
      mem[tail] <= {eob_q, sr_q, sl_q};
    end
    rd_q <= mem[rd_addr];
  end

  // Interpolation in Q.16 with mono substitution.
  logic signed [15:0] l0, l1, r0, r1;
  logic signed [16:0] dl, dr;
  logic signed [16:0] frac;
  assign l0   = f0_q[15:0];
  assign l1   = f1_q[15:0];
  assign r0   = mode_i ? f0_q[31:16] : f0_q[15:0];
  assign r1   = mode_i ? f1_q[31:16] : f1_q[15:0];
  assign dl   = 17'(l1) - 17'(l0);
  assign dr   = 17'(r1) - 17'(r0);
  assign frac = {1'b0, pos_q[15:0]};

  // Truncate toward zero: bias negative products before the shift.
  logic signed [49:0] bl, br;
  assign bl = pl_q + (pl_q[49] ? 50'sh0FFFFFFF : 50'sd0);
  assign br = pr_q + (pr_q[49] ? 50'sh0FFFFFFF : 50'sd0);

  // Control state of the queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      pos_q   <= '0;
      done_q  <= '0;
      under_q <= 1'b0;
      acc_q   <= 1'b0;
      op_q    <= OP_NONE;
    end else begin
      if (cmd_i.capture) begin
        op_q    <= op_i;
        done_q  <= '0;
        under_q <= 1'b0;
        acc_q   <= 1'b0;
      end
      if (cmd_i.push && !full) begin
        count_q <= count_q + CntW'(1);
        acc_q   <= 1'b1;
      end
      if (cmd_i.clear) begin
        head_q  <= '0;
        count_q <= '0;
        pos_q   <= '0;
      end
      if (cmd_i.drop) begin
        pos_q   <= pos_q - PosOne;
        head_q  <= head_q + IdxW'(1);
        count_q <= count_q - CntW'(1);
        done_q  <= done_q + CntW'(rd_q[32]);
      end
      if (cmd_i.set_under) begin
        under_q <= 1'b1;
      end
      if (cmd_i.mul) begin
        pos_q <= pos_sum[24] ? 24'hFFFFFF : pos_sum[23:0];
        acc_q <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sl_q   <= sample_left_i;
      sr_q   <= sample_right_i;
      eob_q  <= end_of_buffer_i;
      accl_q <= acc_left_i;
      accr_q <= acc_right_i;
    end
    if (cmd_i.rd_head) begin
      f0_q <= rd_q;
      f1_q <= rd_q;
    end
    if (cmd_i.rd_next && count_q > CntW'(1)) begin
      f1_q <= rd_q;
    end
    if (cmd_i.sum) begin
      vl_q <= 34'(l0) * 34'sd65536 + 34'(dl) * 34'(frac);
      vr_q <= 34'(r0) * 34'sd65536 + 34'(dr) * 34'(frac);
    end
    if (cmd_i.mul) begin
      pl_q <= 50'(vl_q) * 50'($signed(gain_l_i));
      pr_q <= 50'(vr_q) * 50'($signed(gain_r_i));
    end
    if (cmd_i.load_out) begin
      accepted_o          <= acc_q;
      mixed_left_o        <= (op_q == OP_PULL) ?
                             (under_q ? accl_q : accl_q + 32'(bl >>> 28)) : '0;
      mixed_right_o       <= (op_q == OP_PULL) ?
                             (under_q ? accr_q : accr_q + 32'(br >>> 28)) : '0;
      underrun_o          <= under_q;
      buffers_completed_o <= done_q;
      fifo_level_o        <= count_q;
    end
  end

endmodule

// ===== sv/qprm_ctrl.sv =====
// Controller of the queued PCM resample mixer: sequences push, clear and
// the pull steps (drain, reads, interpolate, multiply, drain, output).
// Depends on qprm_pkg.
module qprm_ctrl
  import qprm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   take;

  assign take = in_valid_i && !in_stall_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (take) state_d = ST_DRAIN1;
      ST_DRAIN1: begin
        if (sts_i.op != OP_PULL) state_d = ST_OUT;
        else if (!sts_i.can_drop) state_d = sts_i.empty ? ST_OUT : ST_RD_HEAD;
      end
      ST_RD_HEAD: state_d = ST_RD_NEXT;
      ST_RD_NEXT: state_d = ST_SUM;
      ST_SUM:     state_d = ST_MUL;
      ST_MUL:     state_d = ST_DRAIN2;
      ST_DRAIN2:  if (!sts_i.can_drop) state_d = ST_OUT;
      ST_OUT:     if (!ovalid_q || !out_stall_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs. Drops are two-phase: the memory read lands the cycle after the
  // address, so a drop is taken only when the registered head is current;
  // head_q is read in every state but ST_RD_HEAD, keeping rd_q tracking the head.
  logic drop_ok_q;
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE:    cmd_o.capture = take;
      ST_DRAIN1: begin
        cmd_o.push  = sts_i.op == OP_PUSH;
        cmd_o.clear = sts_i.op == OP_CLEAR;
        cmd_o.drop  = sts_i.op == OP_PULL && sts_i.can_drop && drop_ok_q;
        cmd_o.set_under = sts_i.op == OP_PULL && !sts_i.can_drop && sts_i.empty;
      end
      ST_RD_HEAD: cmd_o.rd_head = 1'b1;
      ST_RD_NEXT: cmd_o.rd_next = 1'b1;
      ST_SUM:     cmd_o.sum = 1'b1;
      ST_MUL:     cmd_o.mul = 1'b1;
      ST_DRAIN2:  cmd_o.drop = sts_i.can_drop && drop_ok_q;
      ST_OUT:     cmd_o.load_out = !ovalid_q || !out_stall_i;
      default:    cmd_o = '0;
    endcase
  end

  // Drop only on alternate cycles so rd_q reflects the new head.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) drop_ok_q <= 1'b0;
    else drop_ok_q <= !cmd_o.drop && !cmd_o.rd_next;
  end

  // Output valid register.
  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    if (cmd_o.load_out) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = ovalid_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result lost");
  a_no_load_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load_out && ovalid_q && out_stall_i)) else $error("overwrite");
  a_take_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> state_q == ST_DRAIN1) else $error("bad start");

endmodule

// ===== tb/qprm_checker.sv =====
// Checker for the queued PCM resample mixer: watches the item channels and the
// register port, predicts every result and compares it field by field.
// Depends on qprm_pkg.
module qprm_checker
  import qprm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [15:0] sample_left_i,
  input  logic [15:0] sample_right_i,
  input  logic        end_of_buffer_i,
  input  logic [31:0] acc_left_i,
  input  logic [31:0] acc_right_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic        accepted_o,
  input  logic [31:0] mixed_left_o,
  input  logic [31:0] mixed_right_o,
  input  logic        underrun_o,
  input  logic [12:0] buffers_completed_o,
  input  logic [12:0] fifo_level_o,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic        accepted;
    logic [31:0] mixed_left;
    logic [31:0] mixed_right;
    logic        underrun;
    logic [12:0] buffers_completed;
    logic [12:0] fifo_level;
  } mix_result_t;

  // Predicted copy of the block's state and registers.
  logic [32:0] frames [FifoDepth];
  logic [11:0] head;
  int          held;
  logic [23:0] position;
  logic        stereo;
  logic [23:0] step;
  logic [15:0] gain_l, gain_r;
  mix_result_t expected_mix_q[$];

  assign pending_count = expected_mix_q.size();

  function automatic logic [31:0] scaled_mix(logic signed [15:0] a, logic signed [15:0] b,
                                             logic [15:0] frac, logic signed [15:0] gain,
                                             logic [31:0] acc);
    longint v, p, q;
    v = longint'(a) * 65536 + (longint'(b) - longint'(a)) * longint'({1'b0, frac});
    p = v * longint'(gain);
    q = p / 268435456;
    return acc + q[31:0];
  endfunction

  // Drops spent head frames and returns how many buffer ends went with them.
  function automatic int drop_spent();
    int ends;
    ends = 0;
    while (held > 0 && position >= PosOne) begin
      position -= PosOne;
      ends += frames[head][32];
      head++;
      held--;
    end
    return ends;
  endfunction

  function automatic mix_result_t mix_predict(op_e op, logic [15:0] sl, logic [15:0] sr,
                                              logic eob, logic [31:0] al, logic [31:0] ar);
    mix_result_t r;
    logic [32:0] f0, f1;
    logic [15:0] l0, l1, r0, r1;
    logic [24:0] sum;
    int ends;
    r = '{default: '0};
    ends = 0;
    case (op)
      OP_PUSH: begin
        if (held < FifoDepth) begin
          frames[12'(head + held)] = {eob, sr, sl};
          held++;
          r.accepted = 1'b1;
        end
      end
      OP_PULL: begin
        ends = drop_spent();
        if (held == 0) begin
          r.underrun = 1'b1;
          r.mixed_left = al;
          r.mixed_right = ar;
        end else begin
          f0 = frames[head];
          f1 = (held > 1) ? frames[12'(head + 1)] : f0;
          l0 = f0[15:0];
          l1 = f1[15:0];
          r0 = stereo ? f0[31:16] : l0;
          r1 = stereo ? f1[31:16] : l1;
          r.mixed_left = scaled_mix(l0, l1, position[15:0], gain_l, al);
          r.mixed_right = scaled_mix(r0, r1, position[15:0], gain_r, ar);
          r.accepted = 1'b1;
          sum = position + step;
          position = sum[24] ? 24'hFFFFFF : sum[23:0];
          ends += drop_spent();
        end
      end
      OP_CLEAR: begin
        head = '0;
        held = 0;
        position = '0;
      end
      default: ;
    endcase
    r.buffers_completed = 13'(ends);
    r.fifo_level = 13'(held);
    return r;
  endfunction

  // Register writes, then items taken on the input channel, then results.
  always @(posedge clk_i or negedge rst_ni) begin
    mix_result_t exp_r;
    if (!rst_ni) begin
      head = '0;
      held = 0;
      position = '0;
      stereo = 1'b1;
      step = 24'd65536;
      gain_l = 16'd4096;
      gain_r = 16'd4096;
      fail_count = 0;
      expected_mix_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          RegMode:  stereo = pwdata[0];
          RegStep:  step = pwdata[23:0];
          RegGainL: gain_l = pwdata[15:0];
          RegGainR: gain_r = pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o)
        expected_mix_q.push_back(mix_predict(op_e'(op_i), sample_left_i, sample_right_i,
                                             end_of_buffer_i, acc_left_i, acc_right_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_mix_q.size() == 0) begin
          $error("result with no item outstanding");
          fail_count++;
        end else begin
          // Oldest prediction first.
          exp_r = expected_mix_q[0];
          expected_mix_q.delete(0);
          if (accepted_o !== exp_r.accepted) begin
            $error("accepted: expected %0d, got %0d", exp_r.accepted, accepted_o);
            fail_count++;
          end
          if (mixed_left_o !== exp_r.mixed_left) begin
            $error("mixed_left: expected %0h, got %0h", exp_r.mixed_left, mixed_left_o);
            fail_count++;
          end
          if (mixed_right_o !== exp_r.mixed_right) begin
            $error("mixed_right: expected %0h, got %0h", exp_r.mixed_right, mixed_right_o);
            fail_count++;
          end
          if (underrun_o !== exp_r.underrun) begin
            $error("underrun: expected %0d, got %0d", exp_r.underrun, underrun_o);
            fail_count++;
          end
          if (buffers_completed_o !== exp_r.buffers_completed) begin
            $error("buffers_completed: expected %0d, got %0d", exp_r.buffers_completed,
                   buffers_completed_o);
            fail_count++;
          end
          if (fifo_level_o !== exp_r.fifo_level) begin
            $error("fifo_level: expected %0d, got %0d", exp_r.fifo_level, fifo_level_o);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/queued_pcm_resample_mixer_unit_tb.sv =====
// Stimulus and verdict for the queued PCM resample mixer: register phases,
// directed and random push/pull/clear items, random idling on both channels.
// Depends on qprm_pkg, queued_pcm_resample_mixer_unit and qprm_checker.
module queued_pcm_resample_mixer_unit_tb;
  import qprm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = OP_NONE;
  logic [15:0] sample_left_i = '0, sample_right_i = '0;
  logic        end_of_buffer_i = 1'b0;
  logic [31:0] acc_left_i = '0, acc_right_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic        accepted_o, underrun_o;
  logic [31:0] mixed_left_o, mixed_right_o;
  logic [12:0] buffers_completed_o, fifo_level_o;
  int          fail_count, pending_count;

  // Idle rates in percent and the long receiver hold-off request.
  int  send_idle_pct = 24;
  int  recv_idle_pct = 84;
  bit  hold_off = 1'b0;
  bit  driving = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  queued_pcm_resample_mixer_unit u_top (.*);

  qprm_checker u_checker (.*);

  // Receiver stall: random, or held high for a long stretch on request.
  always @(posedge clk_i) begin
    int stretch;
    if (hold_off) begin
      out_stall_i <= 1'b1;
      for (stretch = 0; stretch < 400; stretch++) @(posedge clk_i);
      hold_off = 1'b0;
    end
    if (driving)
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic reg_write(logic [1:0] index, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {index, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Offers one item and waits until the block takes it.
  task automatic send_item(op_e op, logic [15:0] sl, logic [15:0] sr, logic eob,
                           logic [31:0] al, logic [31:0] ar);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op; sample_left_i <= sl; sample_right_i <= sr;
    end_of_buffer_i <= eob; acc_left_i <= al; acc_right_i <= ar;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random(int pull_pct);
    int r;
    op_e op;
    r = $urandom_range(99);
    if (r < 2) op = OP_CLEAR;
    else if (r < 3) op = OP_NONE;
    else if (r < 3 + pull_pct) op = OP_PULL;
    else op = OP_PUSH;
    send_item(op, 16'($urandom), 16'($urandom), ($urandom_range(5) == 0),
              $urandom, $urandom);
  endtask

  // Waits for every outstanding result plus the block's own latency.
  task automatic drain_out();
    int n;
    in_valid_i <= 1'b0;
    n = 0;
    while (pending_count != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_phase(int count, int pull_pct);
    for (int i = 0; i < count; i++) send_random(pull_pct);
  endtask

  initial begin
    int k;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    driving = 1'b1;
    @(posedge clk_i);

    // Directed items: extremes, every op, underrun, single frame.
    send_item(OP_PULL, '0, '0, 1'b0, 32'h7FFFFFFF, 32'h80000000);
    send_item(OP_PUSH, 16'h7FFF, 16'h8000, 1'b1, '0, '0);
    send_item(OP_PULL, '0, '0, 1'b0, 32'h7FFFFFFF, 32'h80000000);
    send_item(OP_PUSH, 16'h8000, 16'h7FFF, 1'b0, '0, '0);
    send_item(OP_PUSH, 16'hFFFF, 16'h0000, 1'b1, '0, '0);
    send_item(OP_PULL, '0, '0, 1'b0, 32'hFFFFFFFF, 32'h00000000);
    send_item(OP_NONE, 16'hFFFF, 16'hFFFF, 1'b1, '1, '1);
    send_item(OP_PULL, '0, '0, 1'b0, 32'h80000000, 32'h7FFFFFFF);
    send_item(OP_CLEAR, '0, '0, 1'b0, '0, '0);
    send_item(OP_PULL, '0, '0, 1'b0, 32'h12345678, 32'h9ABCDEF0);
    drain_out();

    // Extreme gains, mono, fractional step.
    reg_write(RegMode, 32'd0);
    reg_write(RegStep, 32'h004000);
    reg_write(RegGainL, 32'h00008000);
    reg_write(RegGainR, 32'h00007FFF);
    for (k = 0; k < 4; k++)
      send_item(OP_PUSH, k[0] ? 16'h8000 : 16'h7FFF, 16'h1234, k[1], '0, '0);
    for (k = 0; k < 6; k++) send_item(OP_PULL, '0, '0, 1'b0, $urandom, $urandom);
    drain_out();

    // Build up a deep queue.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (k = 0; k < 600; k++)
      send_item(OP_PUSH, 16'($urandom), 16'($urandom), k[0], '0, '0);
    send_item(OP_PUSH, 16'h5555, 16'hAAAA, 1'b1, '0, '0);
    // Maximum step saturates the position and drains many frames at once.
    drain_out();
    reg_write(RegStep, 32'hFFFFFF);
    send_item(OP_PULL, '0, '0, 1'b0, '0, '0);
    send_item(OP_PULL, '0, '0, 1'b0, '0, '0);
    send_item(OP_CLEAR, '0, '0, 1'b0, '0, '0);
    drain_out();

    // Sender idles little, receiver a lot; stereo, step 1 (smallest nonzero).
    send_idle_pct = 24;
    recv_idle_pct = 84;
    reg_write(RegMode, 32'd1);
    reg_write(RegStep, 32'd1);
    reg_write(RegGainL, 32'd4096);
    reg_write(RegGainR, 32'hFFFFF000);
    random_phase(300, 45);
    hold_off = 1'b1;
    random_phase(60, 30);
    drain_out();

    // Roles swapped; upsampling-ish step and random gains.
    send_idle_pct = 84;
    recv_idle_pct = 24;
    reg_write(RegStep, 32'h00C000);
    reg_write(RegGainL, $urandom);
    reg_write(RegGainR, $urandom);
    random_phase(320, 45);
    drain_out();

    // No idling; a downsampling step in mono, then a random step in stereo.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_write(RegMode, 32'd0);
    reg_write(RegStep, 32'h028000);
    random_phase(320, 30);
    drain_out();
    reg_write(RegMode, 32'd1);
    reg_write(RegStep, $urandom_range(24'hFFFFFF, 1) & 32'h03FFFF | 32'd1);
    reg_write(RegGainL, $urandom);
    reg_write(RegGainR, $urandom);
    random_phase(330, 50);
    drain_out();

    if (fail_count == 0 && pending_count == 0)
      $display("PASS queued_pcm_resample_mixer_unit");
    else
      $display("FAIL queued_pcm_resample_mixer_unit");
    $finish;
  end

  // Overall time limit.
  initial begin
    #100ms;
    $display("FAIL queued_pcm_resample_mixer_unit");
    $finish;
  end

endmodule
